FILE: hdl/dgs_pkg.sv
// shared types and constants of the deformation gradient to stress block
package dgs_pkg;

  localparam int STRAIN_W = 48;
  localparam int WT_W     = 17;
  localparam int S_W      = 68;
  localparam int LO_W     = 34;
  localparam int E_W      = 32;
  localparam int NU_W     = 15;
  localparam int DEN_W    = 33;
  localparam int UNIT_Q16 = 65536;
  localparam int NCOMP    = 6;
  localparam int NGRAD    = 9;

  typedef enum logic [2:0] {
    REG_THREE  = 3'd0,
    REG_STRAIN = 3'd1,
    REG_PLANE  = 3'd2,
    REG_YOUNG  = 3'd3,
    REG_NU     = 3'd4
  } reg_idx_t;

  typedef enum int {
    C_XX = 0, C_YY = 1, C_ZZ = 2, C_XY = 3, C_XZ = 4, C_YZ = 5
  } comp_t;

  typedef logic signed [STRAIN_W-1:0] strain_t;
  typedef logic signed [S_W-1:0]      comb_t;

  typedef struct packed {
    logic                three;
    logic                infin;
    logic                plane;
    logic [E_W-1:0]      young;
    logic [NU_W-1:0]     nu;
  } cfg_t;

endpackage

FILE: hdl/dgs_grad_if.sv
// request channel carrying one deformation gradient
interface dgs_grad_if #(parameter int GW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [GW-1:0] grad_a;
  logic signed [GW-1:0] grad_b;
  logic signed [GW-1:0] grad_c;
  logic signed [GW-1:0] grad_d;
  logic signed [GW-1:0] grad_e;
  logic signed [GW-1:0] grad_f;
  logic signed [GW-1:0] grad_g;
  logic signed [GW-1:0] grad_h;
  logic signed [GW-1:0] grad_i;

  modport source (output valid, grad_a, grad_b, grad_c, grad_d, grad_e, grad_f,
                  grad_g, grad_h, grad_i, input ready);
  modport sink   (input valid, grad_a, grad_b, grad_c, grad_d, grad_e, grad_f,
                  grad_g, grad_h, grad_i, output ready);
endinterface

FILE: hdl/dgs_stress_if.sv
// result channel carrying one symmetric stress
interface dgs_stress_if #(parameter int SW = 48);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] stress_xx;
  logic signed [SW-1:0] stress_yy;
  logic signed [SW-1:0] stress_zz;
  logic signed [SW-1:0] stress_xy;
  logic signed [SW-1:0] stress_xz;
  logic signed [SW-1:0] stress_yz;

  modport source (output valid, stress_xx, stress_yy, stress_zz, stress_xy,
                  stress_xz, stress_yz, input ready);
  modport sink   (input valid, stress_xx, stress_yy, stress_zz, stress_xy,
                  stress_xz, stress_yz, output ready);
endinterface

FILE: hdl/deformation_gradient_to_stress.sv
// top level of the deformation gradient to stress pipeline
// Takes one deformation gradient per cycle and returns its stress through a
// pipeline of two strain stages, three hooke-law stages, then a restoring
// divider per component with one compare stage, one stage per quotient bit
// and an output stage; the divider's bit stages set the latency.
// Throughput is one request per cycle;
// the whole pipeline holds while a finished result is not taken. No clearing
// pass is needed after reset. Configuration is read straight from the
// registers, so write it only while no request is in flight.
module deformation_gradient_to_stress #(
  parameter int GRAD_WIDTH     = 32,
  parameter int GRAD_FRAC_BITS = 28,
  parameter int STRESS_WIDTH   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  dgs_grad_if.sink    in_chan,
  dgs_stress_if.source out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dgs_pkg::*;

  // scaling of the quotient: numerator shifted up or divisor shifted up
  localparam int UP   = (GRAD_FRAC_BITS <= 32) ? 32 - GRAD_FRAC_BITS : 0;
  localparam int DOWN = (GRAD_FRAC_BITS > 32) ? GRAD_FRAC_BITS - 32 : 0;
  localparam int NW   = S_W + E_W + 1 + UP;
  localparam int DW   = DEN_W + DOWN;
  localparam int L    = STRESS_WIDTH + 6;

  cfg_t                        cfg;
  logic                        adv;
  logic [L-1:0]                vld_r;
  logic [DW-1:0]               d_r;
  logic [DEN_W-1:0]            den_nxt;
  logic [WT_W-1:0]             nu_x;
  logic signed [GRAD_WIDTH-1:0] grad [NGRAD];
  strain_t                     strain [NCOMP];
  logic [NW:0]                 num [NCOMP];
  logic                        neg [NCOMP];
  logic signed [STRESS_WIDTH-1:0] stress [NCOMP];

  dgs_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // global advance: the output register is empty or is being taken
  assign adv           = !vld_r[L-1] || out_chan.ready;
  assign in_chan.ready = adv;
  assign out_chan.valid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[L-2:0], in_chan.valid};
  end

  // divisor from poisson ratio: plane stress uses (u-n)(u+n), else (u+n)(u-2n)
  assign nu_x = {{(WT_W-NU_W){1'b0}}, cfg.nu};
  always_comb begin
    if (!cfg.three && cfg.plane)
      den_nxt = DEN_W'((DEN_W'(UNIT_Q16) - DEN_W'(nu_x)) *
                       (DEN_W'(UNIT_Q16) + DEN_W'(nu_x)));
    else
      den_nxt = DEN_W'((DEN_W'(UNIT_Q16) + DEN_W'(nu_x)) *
                       (DEN_W'(UNIT_Q16) - DEN_W'(nu_x << 1)));
  end

  always_ff @(posedge clk) begin
    d_r <= DW'(den_nxt) << DOWN;
  end

  assign grad[0] = in_chan.grad_a;
  assign grad[1] = in_chan.grad_b;
  assign grad[2] = in_chan.grad_c;
  assign grad[3] = in_chan.grad_d;
  assign grad[4] = in_chan.grad_e;
  assign grad[5] = in_chan.grad_f;
  assign grad[6] = in_chan.grad_g;
  assign grad[7] = in_chan.grad_h;
  assign grad[8] = in_chan.grad_i;

  // strain, two stages
  dgs_strain #(.GW(GRAD_WIDTH), .FB(GRAD_FRAC_BITS)) u_strain (
    .clk, .adv, .three_i(cfg.three), .infin_i(cfg.infin), .grad_i(grad),
    .strain_o(strain)
  );

  // hooke law, three stages
  dgs_law #(.NW(NW), .UP(UP), .DW(DW)) u_law (
    .clk, .adv, .cfg_i(cfg), .d_i(d_r), .strain_i(strain), .num_o(num), .neg_o(neg)
  );

  // one divider lane per stress component
  for (genvar c = 0; c < NCOMP; c++) begin : g_div
    dgs_div #(.SW(STRESS_WIDTH), .NW(NW), .DW(DW)) u_div (
      .clk, .adv, .d_i(d_r), .num_i(num[c]), .neg_i(neg[c]), .stress_o(stress[c])
    );
  end

  assign out_chan.stress_xx = stress[C_XX];
  assign out_chan.stress_yy = stress[C_YY];
  assign out_chan.stress_zz = stress[C_ZZ];
  assign out_chan.stress_xy = stress[C_XY];
  assign out_chan.stress_xz = stress[C_XZ];
  assign out_chan.stress_yz = stress[C_YZ];
endmodule

FILE: hdl/dgs_cfg.sv
// configuration registers behind the apb-style port
module dgs_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dgs_pkg::cfg_t       cfg_o
);
  import dgs_pkg::*;

  cfg_t cfg_r;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.three <= 1'b1;
      cfg_r.infin <= 1'b0;
      cfg_r.plane <= 1'b0;
      cfg_r.young <= '0;
      cfg_r.nu    <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_THREE:  cfg_r.three <= pwdata[0];
        REG_STRAIN: cfg_r.infin <= pwdata[0];
        REG_PLANE:  cfg_r.plane <= pwdata[0];
        REG_YOUNG:  cfg_r.young <= pwdata[E_W-1:0];
        REG_NU:     cfg_r.nu    <= pwdata[NU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_THREE:  prdata = {31'd0, cfg_r.three};
      REG_STRAIN: prdata = {31'd0, cfg_r.infin};
      REG_PLANE:  prdata = {31'd0, cfg_r.plane};
      REG_YOUNG:  prdata = cfg_r.young;
      REG_NU:     prdata = {{(32-NU_W){1'b0}}, cfg_r.nu};
      default:    prdata = '0;
    endcase
  end
endmodule

FILE: hdl/dgs_strain.sv
// two-stage strain unit: gradient products, then lagrange or infinitesimal strain
module dgs_strain #(
  parameter int GW = 32,
  parameter int FB = 28
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic                 three_i,
  input  logic                 infin_i,
  input  logic signed [GW-1:0] grad_i [dgs_pkg::NGRAD],
  output dgs_pkg::strain_t     strain_o [dgs_pkg::NCOMP]
);
  import dgs_pkg::*;

  localparam int PW   = 2 * GW;
  localparam int SUMW = ((GW > FB) ? PW : 2 * FB) + 3;
  localparam int IW   = ((GW > FB) ? GW : FB + 1) + 2;
  localparam int MW   = (SUMW > IW) ? SUMW : IW;
  localparam int CW   = ((MW > STRAIN_W) ? MW : STRAIN_W) + 1;
  localparam int II [NCOMP] = '{0, 1, 2, 0, 0, 1};
  localparam int JJ [NCOMP] = '{0, 1, 2, 1, 2, 2};
  localparam logic signed [CW-1:0] SMAX = {{(CW-STRAIN_W+1){1'b0}}, {(STRAIN_W-1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {{(CW-STRAIN_W+1){1'b1}}, {(STRAIN_W-1){1'b0}}};

  logic signed [GW-1:0] f      [NGRAD];
  logic signed [GW-1:0] f_r    [NGRAD];
  logic signed [PW-1:0] prod_r [NCOMP][3];
  strain_t              e_nxt  [NCOMP];
  strain_t              e_r    [NCOMP];

  // gradient matrix, row major, third row and column empty in 2d
  always_comb begin
    for (int i = 0; i < NGRAD; i++) f[i] = three_i ? grad_i[i] : '0;
    if (!three_i) begin
      f[0] = grad_i[0];
      f[1] = grad_i[1];
      f[3] = grad_i[2];
      f[4] = grad_i[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r <= f;
      for (int c = 0; c < NCOMP; c++)
        for (int k = 0; k < 3; k++)
          prod_r[c][k] <= f[3*k+II[c]] * f[3*k+JJ[c]];
    end
  end

  always_comb begin
    logic signed [SUMW-1:0] s;
    logic signed [IW-1:0]   v;
    logic signed [CW-1:0]   x;
    for (int c = 0; c < NCOMP; c++) begin
      s = SUMW'(prod_r[c][0]) + SUMW'(prod_r[c][1]) + SUMW'(prod_r[c][2]);
      if (II[c] == JJ[c]) s = s - (SUMW'(1) <<< (2 * FB));
      s = s >>> (FB + 1);
      if (II[c] == JJ[c]) v = IW'(f_r[4*II[c]]) - (IW'(1) <<< FB);
      else v = (IW'(f_r[3*II[c]+JJ[c]]) + IW'(f_r[3*JJ[c]+II[c]])) >>> 1;
      x = infin_i ? CW'(v) : CW'(s);
      if (x > SMAX) x = SMAX;
      else if (x < SMIN) x = SMIN;
      e_nxt[c] = x[STRAIN_W-1:0];
      if (!three_i && (c == C_ZZ || c == C_XZ || c == C_YZ)) e_nxt[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) e_r <= e_nxt;
  end

  assign strain_o = e_r;
endmodule

FILE: hdl/dgs_law.sv
// three-stage hooke law: weighted strain sums, modulus product, rounded magnitude
module dgs_law #(
  parameter int NW = 105,
  parameter int UP = 4,
  parameter int DW = 33
) (
  input  logic             clk,
  input  logic             adv,
  input  dgs_pkg::cfg_t    cfg_i,
  input  logic [DW-1:0]    d_i,
  input  dgs_pkg::strain_t strain_i [dgs_pkg::NCOMP],
  output logic [NW:0]      num_o    [dgs_pkg::NCOMP],
  output logic             neg_o    [dgs_pkg::NCOMP]
);
  import dgs_pkg::*;

  localparam int HI_W = S_W - LO_W;

  logic                    ps;
  logic [WT_W-1:0]         w_own, w_oth, w_shr, nu_x;
  logic signed [WT_W:0]    so, sx, ss;
  comb_t                   s_r   [NCOMP];
  logic signed [LO_W+E_W+1:0] lo_r [NCOMP];
  logic signed [HI_W+E_W:0]   hi_r [NCOMP];
  logic [NW:0]             num_nxt [NCOMP];
  logic                    neg_nxt [NCOMP];
  logic signed [E_W:0]     e_s;

  // plane stress only in 2d
  assign ps    = !cfg_i.three && cfg_i.plane;
  assign nu_x  = {{(WT_W-NU_W){1'b0}}, cfg_i.nu};
  assign w_own = ps ? WT_W'(UNIT_Q16) : WT_W'(UNIT_Q16) - nu_x;
  assign w_oth = nu_x;
  assign w_shr = ps ? WT_W'(UNIT_Q16) - nu_x : WT_W'(UNIT_Q16) - (nu_x << 1);
  assign so    = $signed({1'b0, w_own});
  assign sx    = $signed({1'b0, w_oth});
  assign ss    = $signed({1'b0, w_shr});
  assign e_s   = $signed({1'b0, cfg_i.young});

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r[C_XX] <= S_W'(strain_i[C_XX] * so) + S_W'(strain_i[C_YY] * sx)
                 + S_W'(strain_i[C_ZZ] * sx);
      s_r[C_YY] <= S_W'(strain_i[C_XX] * sx) + S_W'(strain_i[C_YY] * so)
                 + S_W'(strain_i[C_ZZ] * sx);
      s_r[C_ZZ] <= ps ? '0 : S_W'(strain_i[C_XX] * sx) + S_W'(strain_i[C_YY] * sx)
                 + S_W'(strain_i[C_ZZ] * so);
      s_r[C_XY] <= S_W'(strain_i[C_XY] * ss);
      s_r[C_XZ] <= S_W'(strain_i[C_XZ] * ss);
      s_r[C_YZ] <= S_W'(strain_i[C_YZ] * ss);
    end
  end

  // modulus product split in two partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NCOMP; c++) begin
        lo_r[c] <= $signed({1'b0, s_r[c][LO_W-1:0]}) * e_s;
        hi_r[c] <= $signed(s_r[c][S_W-1:LO_W]) * e_s;
      end
    end
  end

  always_comb begin : mag_blk
    logic signed [NW-1:0] n;
    logic [NW-1:0]        m;
    for (int c = 0; c < NCOMP; c++) begin
      n = ((NW'(hi_r[c]) <<< LO_W) + NW'(lo_r[c])) <<< UP;
      m = n[NW-1] ? NW'(-n) : NW'(n);
      num_nxt[c] = {1'b0, m} + (NW+1)'(d_i >> 1);
      neg_nxt[c] = n[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_o <= num_nxt;
      neg_o <= neg_nxt;
    end
  end
endmodule

FILE: hdl/dgs_div.sv
// pipelined restoring divider, one quotient bit a stage, with saturation
module dgs_div #(
  parameter int SW = 48,
  parameter int NW = 105,
  parameter int DW = 33
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [DW-1:0]        d_i,
  input  logic [NW:0]          num_i,
  input  logic                 neg_i,
  output logic signed [SW-1:0] stress_o
);
  localparam int RW = ((NW + 1) > (DW + SW - 1)) ? (NW + 1) : (DW + SW - 1);
  localparam logic signed [SW-1:0] QMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] QMIN = {1'b1, {(SW-1){1'b0}}};

  logic [RW-1:0] rem_r [SW];
  logic [SW-2:0] q_r   [SW];
  logic          neg_r [SW];
  logic          sat_r [SW];
  logic [RW-1:0] num_x, lim;
  logic signed [SW-1:0] out_r;

  assign num_x = RW'(num_i);
  assign lim   = RW'(d_i) << (SW - 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num_x;
      q_r[0]   <= '0;
      neg_r[0] <= neg_i;
      sat_r[0] <= num_x >= lim;
    end
  end

  for (genvar k = 1; k < SW; k++) begin : g_bit
    localparam int B = SW - 1 - k;
    logic [RW-1:0] t;
    logic          take;
    assign t    = RW'(d_i) << B;
    assign take = rem_r[k-1] >= t;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? rem_r[k-1] - t : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | ((SW-1)'(take) << B);
        neg_r[k] <= neg_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sat_r[SW-1]) out_r <= neg_r[SW-1] ? QMIN : QMAX;
      else if (neg_r[SW-1]) out_r <= -$signed({1'b0, q_r[SW-1]});
      else out_r <= $signed({1'b0, q_r[SW-1]});
    end
  end

  assign stress_o = out_r;
endmodule

FILE: tb/dgs_stress_checker.sv
// checker that predicts and compares the stress of each accepted gradient
module dgs_stress_checker (
  input  logic        clk,
  input  logic        rst_n,
  dgs_grad_if         grad,
  dgs_stress_if       stress,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dgs_pkg::*;

  typedef logic signed [127:0] big_t;
  typedef struct packed {
    logic signed [47:0] xx, yy, zz, xy, xz, yz;
  } stress_val_t;

  cfg_t        cur_cfg;
  stress_val_t stress_q[$];

  function automatic big_t clamp_to(input big_t v, input int bits);
    big_t top;
    top = (big_t'(1) <<< (bits - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // stress = E * s * 2^4 / den, rounded half away from zero, saturated
  function automatic logic [47:0] hooke_div(input big_t s, input logic [31:0] young,
                                            input logic [63:0] den);
    big_t num, res;
    logic [127:0] mag, quo;
    logic neg;
    num = (s * $signed({96'd0, young})) <<< 4;
    neg = num < 0;
    mag = neg ? -num : num;
    quo = (mag + {64'd0, den >> 1}) / {64'd0, den};
    res = neg ? -$signed(quo) : $signed(quo);
    res = clamp_to(res, 48);
    return res[47:0];
  endfunction

  function automatic stress_val_t predict_stress(input logic [31:0] g[9], input cfg_t c);
    big_t f[3][3], e[3][3];
    big_t v, n, u;
    logic [63:0] den;
    int dims;
    stress_val_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        f[i][j] = '0;
        e[i][j] = '0;
      end
    dims = c.three ? 3 : 2;
    if (c.three) begin
      for (int i = 0; i < 9; i++) f[i / 3][i % 3] = big_t'($signed(g[i]));
    end else begin
      f[0][0] = big_t'($signed(g[0]));
      f[0][1] = big_t'($signed(g[1]));
      f[1][0] = big_t'($signed(g[2]));
      f[1][1] = big_t'($signed(g[3]));
    end
    for (int i = 0; i < dims; i++)
      for (int j = i; j < dims; j++) begin
        if (!c.infin) begin
          v = '0;
          for (int k = 0; k < dims; k++) v = v + f[k][i] * f[k][j];
          if (i == j) v = v - (big_t'(1) <<< 56);
          v = v >>> 29;
        end else if (i == j) begin
          v = f[i][i] - (big_t'(1) <<< 28);
        end else begin
          v = (f[i][j] + f[j][i]) >>> 1;
        end
        v = clamp_to(v, STRAIN_W);
        e[i][j] = v;
        e[j][i] = v;
      end
    n = big_t'(c.nu);
    u = big_t'(UNIT_Q16);
    if (c.three || !c.plane) begin
      den = 64'((u + n) * (u - 2 * n));
      r.xx = hooke_div(e[0][0] * (u - n) + e[1][1] * n + e[2][2] * n, c.young, den);
      r.yy = hooke_div(e[0][0] * n + e[1][1] * (u - n) + e[2][2] * n, c.young, den);
      r.zz = hooke_div(e[0][0] * n + e[1][1] * n + e[2][2] * (u - n), c.young, den);
      r.xy = hooke_div(e[0][1] * (u - 2 * n), c.young, den);
      r.xz = hooke_div(e[0][2] * (u - 2 * n), c.young, den);
      r.yz = hooke_div(e[1][2] * (u - 2 * n), c.young, den);
    end else begin
      den = 64'((u - n) * (u + n));
      r.xx = hooke_div(e[0][0] * u + e[1][1] * n, c.young, den);
      r.yy = hooke_div(e[0][0] * n + e[1][1] * u, c.young, den);
      r.zz = '0;
      r.xy = hooke_div(e[0][1] * (u - n), c.young, den);
      r.xz = '0;
      r.yz = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  assign pending = stress_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [31:0] g[9];
    stress_val_t want;
    if (!rst_n) begin
      cur_cfg <= '{three: 1'b1, infin: 1'b0, plane: 1'b0, young: '0, nu: '0};
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_THREE:  cur_cfg.three <= pwdata[0];
          REG_STRAIN: cur_cfg.infin <= pwdata[0];
          REG_PLANE:  cur_cfg.plane <= pwdata[0];
          REG_YOUNG:  cur_cfg.young <= pwdata;
          REG_NU:     cur_cfg.nu <= pwdata[NU_W-1:0];
          default: ;
        endcase
      end
      if (grad.valid && grad.ready) begin
        g = '{grad.grad_a, grad.grad_b, grad.grad_c, grad.grad_d, grad.grad_e,
              grad.grad_f, grad.grad_g, grad.grad_h, grad.grad_i};
        stress_q.push_back(predict_stress(g, cur_cfg));
      end
      if (stress.valid && stress.ready) begin
        if (stress_q.size() == 0) begin
          $error("stress result with no request outstanding");
          fail_count++;
        end else begin
          want = stress_q.pop_front();
          check_field("stress_xx", want.xx, stress.stress_xx);
          check_field("stress_yy", want.yy, stress.stress_yy);
          check_field("stress_zz", want.zz, stress.stress_zz);
          check_field("stress_xy", want.xy, stress.stress_xy);
          check_field("stress_xz", want.xz, stress.stress_xz);
          check_field("stress_yz", want.yz, stress.stress_yz);
        end
      end
    end
  end
endmodule

FILE: tb/testbench.sv
// top of the stress block testbench: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dgs_pkg::*;

  localparam int DRAIN_CYCLES = 60;     // covers the full pipeline latency
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;    // long enough to fill the pipeline
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 160;
  localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  int          cycles;
  bit          calm;        // no idling in the last part of the run
  bit          long_hold;   // asks the result side for one long stall

  dgs_grad_if   #(.GW(32)) grad_ch ();
  dgs_stress_if #(.SW(48)) stress_ch ();

  deformation_gradient_to_stress dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (grad_ch.sink),
    .out_chan (stress_ch.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dgs_stress_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .grad       (grad_ch),
    .stress     (stress_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold when asked
  initial begin
    int n;
    stress_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        stress_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        stress_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        stress_ch.ready <= 1'b1;
      end
    end
  end

  // register write: setup cycle then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // junk in the unused upper bits, which the block must ignore
  task automatic load_config(input bit three, input bit infin, input bit plane,
                             input logic [31:0] young, input logic [14:0] nu);
    reg_write(REG_THREE,  {$urandom} & 32'hFFFF_FFFE | three);
    reg_write(REG_STRAIN, {$urandom} & 32'hFFFF_FFFE | infin);
    reg_write(REG_PLANE,  {$urandom} & 32'hFFFF_FFFE | plane);
    reg_write(REG_YOUNG,  young);
    reg_write(REG_NU,     {$urandom} & 32'hFFFF_8000 | nu);
    // unknown index, must be dropped
    reg_write(3'($urandom_range(5, 7)), $urandom);
  endtask

  // one gradient request; returns at a falling edge with valid still high
  task automatic send_grad(input logic [31:0] g[9]);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      grad_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    grad_ch.valid  <= 1'b1;
    grad_ch.grad_a <= g[0];
    grad_ch.grad_b <= g[1];
    grad_ch.grad_c <= g[2];
    grad_ch.grad_d <= g[3];
    grad_ch.grad_e <= g[4];
    grad_ch.grad_f <= g[5];
    grad_ch.grad_g <= g[6];
    grad_ch.grad_h <= g[7];
    grad_ch.grad_i <= g[8];
    do @(posedge clk); while (!grad_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] grad_entry(input int kind, input bit diag);
    logic [31:0] pert;
    case (kind)
      // physical deformation: identity plus a modest perturbation
      0: begin
        pert = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        return diag ? ONE_Q28 + pert : pert;
      end
      // extremes
      1: case ($urandom_range(0, 5))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'hFFFF_FFFF;
           4: return ONE_Q28;
           default: return -ONE_Q28;
         endcase
      default: return $urandom;
    endcase
  endfunction

  task automatic random_grad(output logic [31:0] g[9]);
    int r, kind;
    r = $urandom_range(0, 9);
    kind = (r < 6) ? 0 : (r < 8) ? 2 : 1;
    for (int i = 0; i < 9; i++) g[i] = grad_entry(kind, i == 0 || i == 4 || i == 8);
  endtask

  task automatic directed_grads();
    logic [31:0] g[9];
    // identity gives zero strain
    g = '{ONE_Q28, 0, 0, 0, ONE_Q28, 0, 0, 0, ONE_Q28};
    send_grad(g);
    g = '{default: 32'h0};
    send_grad(g);
    g = '{default: 32'h7FFF_FFFF};
    send_grad(g);
    g = '{default: 32'h8000_0000};
    send_grad(g);
    g = '{default: 32'hFFFF_FFFF};
    send_grad(g);
    // largest strain, mixed signs
    g = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_grad(g);
    g = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_grad(g);
    // pure shear with small off-diagonal entries
    g = '{ONE_Q28, 32'h1, 32'h3, 32'hFFFF_FFFF, ONE_Q28, 32'h5, 32'hFFFF_FFFD, 32'h7,
          ONE_Q28};
    send_grad(g);
    // uniform stretch and compression
    g = '{32'h1100_0000, 0, 0, 0, 32'h1100_0000, 0, 0, 0, 32'h1100_0000};
    send_grad(g);
    g = '{32'h0F00_0000, 0, 0, 0, 32'h0F00_0000, 0, 0, 0, 32'h0F00_0000};
    send_grad(g);
    // in-plane values with random out-of-plane fields
    for (int k = 0; k < 4; k++) begin
      g = '{ONE_Q28 + 32'h10_0000, 32'h8_0000, 32'hFFF8_0000, ONE_Q28 - 32'h20_0000,
            $urandom, $urandom, $urandom, $urandom, $urandom};
      send_grad(g);
    end
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [31:0] g[9];
    bit          p_three, p_infin, p_plane;
    logic [31:0] p_young;
    logic [14:0] p_nu;

    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    calm    = 0;
    long_hold = 0;
    grad_ch.valid = 1'b0;
    {grad_ch.grad_a, grad_ch.grad_b, grad_ch.grad_c, grad_ch.grad_d, grad_ch.grad_e,
     grad_ch.grad_f, grad_ch.grad_g, grad_ch.grad_h, grad_ch.grad_i} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // configuration per phase: both dimensions, both strains, both plane
      // kinds, extremes of modulus and ratio
      p_three = ph[0];
      p_infin = ph[1];
      p_plane = ph[2];
      case (ph % 5)
        0: begin p_young = 32'd200000;    p_nu = 15'd19661; end
        1: begin p_young = 32'hFFFF_FFFF; p_nu = 15'h7FFF;  end
        2: begin p_young = 32'd0;         p_nu = 15'($urandom); end
        3: begin p_young = $urandom;      p_nu = 15'd0;     end
        default: begin p_young = $urandom_range(1, 5000000); p_nu = 15'($urandom); end
      endcase
      if (ph == 0) begin
        p_three = 1;
        p_infin = 0;
      end
      load_config(p_three, p_infin, p_plane, p_young, p_nu);
      if (ph == 0 || ph == 4) directed_grads();
      if (ph == NUM_PHASES - 1) calm = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long stall on the result side while requests keep coming
        if (ph == 2 && k == 10) long_hold = 1;
        random_grad(g);
        send_grad(g);
      end
      grad_ch.valid <= 1'b0;
      @(negedge clk);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
